@@ design/pbr_pkg.sv @@
// ----------------------------------------------------------------------------
// Progress bar rasterizer package
// Shared word types, status codes and bar geometry constants.
// ----------------------------------------------------------------------------
package pbr_pkg;

    localparam int ROW_BYTES_DEF    = 20;
    localparam int SCREEN_WIDTH_DEF = 160;
    localparam int FRAME_BYTES_DEF  = 860;

    localparam int BAR_WIDTH = 102;
    localparam int BAR_ROWS  = 7;
    localparam int BAR_BYTES = 13;
    localparam int PCT_MAX   = 100;

    localparam logic [7:0] EDGE_LAST  = 8'hFC;
    localparam logic [7:0] CHECK_ODD  = 8'hAA;
    localparam logic [7:0] CHECK_EVEN = 8'h55;
    localparam logic [7:0] BORDER_L   = 8'h80;
    localparam logic [7:0] BORDER_R   = 8'h04;
    localparam logic [7:0] BYTE_FULL  = 8'hFF;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_X_RANGE = 2'd1;
    localparam logic [1:0] ST_FRAME   = 2'd2;

    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

    typedef struct packed {
        logic [6:0] percent;
        logic [7:0] x_pos;
        logic [5:0] y_pos;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  row_address;
        logic [63:0] bytes_low;
        logic [39:0] bytes_high;
        logic        merge_last;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] percent;
        logic [9:0] base;
    } t_desc;

endpackage

@@ design/pbr_front.sv @@
// ----------------------------------------------------------------------------
// Progress bar front end
// Accepts requests, saturates the fill level, checks the bar against the
// frame and works out the base address, then queues a descriptor.
// ----------------------------------------------------------------------------
module pbr_front #(
    parameter int ROW_BYTES    = pbr_pkg::ROW_BYTES_DEF,
    parameter int SCREEN_WIDTH = pbr_pkg::SCREEN_WIDTH_DEF,
    parameter int FRAME_BYTES  = pbr_pkg::FRAME_BYTES_DEF
) (
    input  logic           i_push,
    input  pbr_pkg::t_in   i_data,
    output logic           o_full,
    output logic           o_q_push,
    output pbr_pkg::t_desc o_q_desc,
    input  logic           i_q_full
);

    localparam logic [9:0]  XLimit   = 10'(SCREEN_WIDTH - 1);
    localparam logic [6:0]  RowLimit = 7'(ROW_BYTES);
    localparam logic [12:0] EndOff   =
        13'(ROW_BYTES * (pbr_pkg::BAR_ROWS - 1) + pbr_pkg::BAR_BYTES - 1);

    logic [9:0]  x_sum;
    logic [4:0]  x_byte;
    logic [11:0] row_base;
    logic [12:0] base;
    logic [12:0] bar_end;
    logic        too_right;
    logic        overrun;

    always_comb begin
        x_sum     = {2'b00, i_data.x_pos} + 10'(pbr_pkg::BAR_WIDTH);
        x_byte    = i_data.x_pos[7:3];
        row_base  = 12'(ROW_BYTES) * {6'b0, i_data.y_pos};
        base      = {1'b0, row_base} + {8'b0, x_byte};
        bar_end   = base + EndOff;
        too_right = x_sum > XLimit;
        overrun   = ({2'b00, x_byte} + 7'(pbr_pkg::BAR_BYTES) > RowLimit) ||
                    (bar_end >= 13'(FRAME_BYTES));

        o_q_desc.percent = (i_data.percent > 7'(pbr_pkg::PCT_MAX)) ?
                           7'(pbr_pkg::PCT_MAX) : i_data.percent;
        o_q_desc.base    = base[9:0];
        if (too_right) begin
            o_q_desc.status = pbr_pkg::ST_X_RANGE;
        end else if (overrun) begin
            o_q_desc.status = pbr_pkg::ST_FRAME;
        end else begin
            o_q_desc.status = pbr_pkg::ST_OK;
        end
    end

    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full;

endmodule

@@ design/pbr_queue.sv @@
// ----------------------------------------------------------------------------
// Progress bar descriptor queue
// Short queue between front end and row sequencer.
// ----------------------------------------------------------------------------
module pbr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pbr_pkg::t_desc i_desc,
    output logic           o_full,
    output logic           o_valid,
    output pbr_pkg::t_desc o_desc,
    input  logic           i_pop
);

    localparam int AW = pbr_pkg::QUEUE_AW;

    pbr_pkg::t_desc r_mem [pbr_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [AW:0]    r_cnt;
    logic [AW:0]    n_cnt;

    assign o_full  = r_cnt == (AW + 1)'(pbr_pkg::QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_desc  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !(i_pop && o_valid)) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop && o_valid) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop && o_valid) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

endmodule

@@ design/pbr_back.sv @@
// ----------------------------------------------------------------------------
// Progress bar row sequencer
// Walks the seven rows of a queued bar (or one error word), builds each row's
// bytes and loads one row word a cycle into the output register when free.
// ----------------------------------------------------------------------------
module pbr_back #(
    parameter int ROW_BYTES = pbr_pkg::ROW_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  pbr_pkg::t_desc i_q_desc,
    output logic           o_q_pop,
    output logic           o_empty,
    output pbr_pkg::t_out  o_data,
    input  logic           i_pop
);

    localparam logic [2:0] LastRow = 3'(pbr_pkg::BAR_ROWS - 1);

    logic [2:0]     r_row;
    logic [8:0]     r_off;
    pbr_pkg::t_out  r_out;
    logic           r_out_vld;
    pbr_pkg::t_out  n_out;

    logic           load;
    logic           is_err;
    logic           is_edge;
    logic           odd;
    logic [3:0]     pb;
    logic [2:0]     ls;
    logic [7:0]     b1;
    logic [7:0]     cb;
    logic [7:0]     part_chk;
    logic [7:0]     part_full;
    logic [7:0]     row_b [pbr_pkg::BAR_BYTES];

    assign o_empty = !r_out_vld;
    assign o_data  = r_out;
    assign is_err  = i_q_desc.status != pbr_pkg::ST_OK;
    assign load    = i_q_valid && (!r_out_vld || i_pop);
    assign o_q_pop = load && (is_err || r_row == LastRow);

    always_comb begin
        is_edge   = (r_row == 3'd0) || (r_row == LastRow);
        odd       = r_row[0];
        pb        = i_q_desc.percent[6:3];
        ls        = ~i_q_desc.percent[2:0];
        b1        = odd ? pbr_pkg::CHECK_ODD : pbr_pkg::CHECK_EVEN;
        cb        = ls[0] ? ~b1 : b1;
        part_chk  = cb << ls;
        part_full = pbr_pkg::BYTE_FULL << ls;

        for (int i = 0; i < pbr_pkg::BAR_BYTES - 1; i++) begin
            if (is_edge) begin
                row_b[i] = pbr_pkg::BYTE_FULL;
            end else if (4'(i) < pb) begin
                row_b[i] = (i < 8) ? b1 : pbr_pkg::BYTE_FULL;
            end else if (4'(i) == pb) begin
                row_b[i] = (i < 8) ? part_chk : part_full;
            end else begin
                row_b[i] = 8'h00;
            end
        end
        if (is_edge) begin
            row_b[pbr_pkg::BAR_BYTES - 1] = pbr_pkg::EDGE_LAST;
        end else begin
            row_b[pbr_pkg::BAR_BYTES - 1] = pbr_pkg::BORDER_R |
                ((pb == 4'(pbr_pkg::BAR_BYTES - 1)) ? part_full : 8'h00);
            row_b[0] = row_b[0] | pbr_pkg::BORDER_L;
        end

        n_out.status      = i_q_desc.status;
        n_out.row_address = i_q_desc.base + {1'b0, r_off};
        for (int k = 0; k < 8; k++) begin
            n_out.bytes_low[8*k +: 8] = row_b[k];
        end
        for (int k = 0; k < 5; k++) begin
            n_out.bytes_high[8*k +: 8] = row_b[8 + k];
        end
        n_out.merge_last = is_edge;
        n_out.last       = r_row == LastRow;
        if (is_err) begin
            n_out.row_address = '0;
            n_out.bytes_low   = '0;
            n_out.bytes_high  = '0;
            n_out.merge_last  = 1'b0;
            n_out.last        = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_row     <= '0;
            r_off     <= '0;
        end else begin
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
            if (o_q_pop) begin
                r_row <= '0;
                r_off <= '0;
            end else if (load) begin
                r_row <= r_row + 1'b1;
                r_off <= r_off + 9'(ROW_BYTES);
            end
        end
    end

endmodule

@@ design/progress_bar_rasterizer.sv @@
// ----------------------------------------------------------------------------
// Progress bar rasterizer
// Renders a seven-row, 13-byte progress bar into row writes for a
// 1-bit-per-pixel frame buffer, or one error word for a bad position.
// ----------------------------------------------------------------------------
// Path from push to result ports: descriptor queue, then output register.
// A drawn bar yields seven row words, a rejected request one error word; the
// row sequencer loads one row word a cycle into the output register if free.
// Reset: synchronous, empties the descriptor queue and the output register.
module progress_bar_rasterizer #(
    parameter int ROW_BYTES    = pbr_pkg::ROW_BYTES_DEF,
    parameter int SCREEN_WIDTH = pbr_pkg::SCREEN_WIDTH_DEF,
    parameter int FRAME_BYTES  = pbr_pkg::FRAME_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  pbr_pkg::t_in  i_data,
    output logic          empty,
    input  logic          pop,
    output pbr_pkg::t_out o_data
);

    logic           q_push;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    pbr_pkg::t_desc q_in;
    pbr_pkg::t_desc q_out;

    pbr_front #(
        .ROW_BYTES    (ROW_BYTES),
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .FRAME_BYTES  (FRAME_BYTES)
    ) u_front (
        .i_push   (push),
        .i_data   (i_data),
        .o_full   (full),
        .o_q_push (q_push),
        .o_q_desc (q_in),
        .i_q_full (q_full)
    );

    pbr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_desc  (q_out),
        .i_pop   (q_pop)
    );

    pbr_back #(
        .ROW_BYTES (ROW_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_desc  (q_out),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .o_data    (o_data),
        .i_pop     (pop)
    );

endmodule
